// ----- rtl/text_mode_console_writer_unit_assert.svh -----
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TMCW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define TMCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMCW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define TMCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/tmcw_pkg.sv -----
// Types, constants and control structs of the text-mode console writer.
package tmcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = $clog2(CELLS + 1);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TEXT_ATTR = CFG_ADDR_W'(0);
  localparam logic [7:0] ATTR_RESET = 8'd7;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       char_code;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [IDX_W-1:0] cursor_offset;
    logic [7:0]       read_char;
    logic [7:0]       read_attr;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  typedef enum logic [1:0] {
    PTR_SEL_ZERO = 2'd0,
    PTR_SEL_COPY = 2'd1,
    PTR_SEL_LAST = 2'd2
  } ptr_sel_t;

  typedef struct packed {
    logic     capture;
    logic     exec;
    logic     ptr_ld;
    ptr_sel_t ptr_sel;
    logic     copy;
    logic     fill;
    logic     fill_zero;
  } ctl_t;

  typedef struct packed {
    logic is_clear;
    logic needs_scroll;
    logic copy_end;
    logic fill_end;
  } sts_t;

endpackage

// ----- rtl/tmcw_ctrl.sv -----
// Sequencing state machine of the console writer.
`include "text_mode_console_writer_unit_assert.svh"
module tmcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_strobe,
  input  tmcw_pkg::sts_t sts,
  output tmcw_pkg::ctl_t ctl
);
  import tmcw_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FILL   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_INIT: begin
        ctl.fill      = 1'b1;
        ctl.fill_zero = 1'b1;
        if (sts.fill_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.is_clear) begin
          ctl.ptr_ld  = 1'b1;
          ctl.ptr_sel = PTR_SEL_ZERO;
          state_nxt   = ST_FILL;
        end else if (sts.needs_scroll) begin
          ctl.ptr_ld  = 1'b1;
          ctl.ptr_sel = PTR_SEL_COPY;
          state_nxt   = ST_SCROLL;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        ctl.copy = 1'b1;
        if (sts.copy_end) begin
          ctl.ptr_ld  = 1'b1;
          ctl.ptr_sel = PTR_SEL_LAST;
          state_nxt   = ST_FILL;
        end
      end
      ST_FILL: begin
        ctl.fill = 1'b1;
        if (sts.fill_end) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = valid_r;

  `TMCW_ASSERT_SAME(a_strobe_not_busy, clk, rst_n, out_strobe, !busy, "strobe while busy")
  `TMCW_ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, state_r == ST_EXEC, "accept lost")
  `TMCW_ASSERT_NEXT(a_fill_result, clk, rst_n, (state_r == ST_FILL) && sts.fill_end, out_strobe, "fill ended without result")

endmodule

// ----- rtl/tmcw_datapath.sv -----
// Screen store, cursor registers and address logic of the console writer.
`include "text_mode_console_writer_unit_assert.svh"
module tmcw_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tmcw_pkg::ctl_t      ctl,
  output tmcw_pkg::sts_t      sts,
  input  tmcw_pkg::in_item_t  in_item,
  input  logic [7:0]          text_attr,
  output tmcw_pkg::out_item_t out_item
);
  import tmcw_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [IDX_W-1:0] LAST_ROW_OFF = IDX_W'((ROWS - 1) * COLUMNS);
  localparam logic [IDX_W-1:0] IDX_COLUMNS  = IDX_W'(COLUMNS);
  localparam logic [IDX_W-1:0] IDX_CELLS    = IDX_W'(CELLS);
  localparam logic [PTR_W-1:0] PTR_CELLS    = PTR_W'(CELLS);
  localparam logic [PTR_W-1:0] PTR_FILL_END = PTR_W'(CELLS - 1);
  localparam logic [PTR_W-1:0] PTR_COLUMNS  = PTR_W'(COLUMNS);
  localparam logic [PTR_W-1:0] PTR_COPY_OFF = PTR_W'(COLUMNS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST_ROW = PTR_W'(CELLS - COLUMNS);

  cell_t mem [CELLS];

  in_item_t         item_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] offset_r, offset_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             read_hit_r, read_hit_nxt;
  cell_t            rd_data_r;

  logic              is_cr, is_lf, is_put, line_adv, col_last, row_last, read_ok;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  cell_t             wdata;
  logic [PTR_W-1:0]  copy_dst;
  logic [IDX_W-1:0]  line_start;

  assign is_cr    = (item_r.char_code == CHAR_CR);
  assign is_lf    = (item_r.char_code == CHAR_LF);
  assign is_put   = (item_r.cmd == CMD_PUT);
  assign col_last = (col_r == COL_LAST);
  assign row_last = (row_r == ROW_LAST);
  assign line_adv = is_lf || (!is_cr && col_last);
  assign read_ok  = (item_r.cmd == CMD_READ) && (item_r.cell_index < IDX_CELLS);
  assign copy_dst = ptr_r - PTR_COPY_OFF;
  assign line_start = offset_r - IDX_W'(col_r);

  assign sts.is_clear     = (item_r.cmd == CMD_CLEAR);
  assign sts.needs_scroll = is_put && line_adv && row_last;
  assign sts.copy_end     = (ptr_r == PTR_CELLS);
  assign sts.fill_end     = (ptr_r == PTR_FILL_END);

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    offset_nxt   = offset_r;
    read_hit_nxt = read_hit_r;
    if (ctl.exec) begin
      read_hit_nxt = read_ok;
      case (item_r.cmd)
        CMD_PUT: begin
          if (is_cr) begin
            col_nxt    = '0;
            offset_nxt = line_start;
          end else if (line_adv) begin
            col_nxt = '0;
            if (row_last) begin
              offset_nxt = LAST_ROW_OFF;
            end else begin
              row_nxt    = row_r + 1'b1;
              offset_nxt = line_start + IDX_COLUMNS;
            end
          end else begin
            col_nxt    = col_r + 1'b1;
            offset_nxt = offset_r + 1'b1;
          end
        end
        CMD_CLEAR: begin
          col_nxt    = '0;
          row_nxt    = '0;
          offset_nxt = '0;
        end
        default: begin
          col_nxt = col_r;
        end
      endcase
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctl.ptr_ld) begin
      case (ctl.ptr_sel)
        PTR_SEL_ZERO: ptr_nxt = '0;
        PTR_SEL_COPY: ptr_nxt = PTR_COLUMNS;
        PTR_SEL_LAST: ptr_nxt = PTR_LAST_ROW;
        default:      ptr_nxt = '0;
      endcase
    end else if (ctl.copy || ctl.fill) begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = ptr_r[ADDR_W-1:0];
    raddr = ptr_r[ADDR_W-1:0];
    wdata = rd_data_r;
    if (ctl.exec) begin
      we    = is_put && !is_cr && !is_lf;
      waddr = offset_r[ADDR_W-1:0];
      wdata = '{ch: item_r.char_code, attr: text_attr};
      re    = read_ok;
      raddr = item_r.cell_index[ADDR_W-1:0];
    end else if (ctl.copy) begin
      re    = (ptr_r < PTR_CELLS);
      we    = (ptr_r > PTR_COLUMNS);
      waddr = copy_dst[ADDR_W-1:0];
    end else if (ctl.fill) begin
      we    = 1'b1;
      wdata = ctl.fill_zero ? cell_t'('0) : cell_t'{ch: CHAR_SPACE, attr: text_attr};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      offset_r   <= '0;
      ptr_r      <= '0;
      read_hit_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      offset_r   <= offset_nxt;
      ptr_r      <= ptr_nxt;
      read_hit_r <= read_hit_nxt;
    end
  end

  assign out_item.cursor_col    = col_r;
  assign out_item.cursor_row    = row_r;
  assign out_item.cursor_offset = offset_r;
  assign out_item.read_char     = read_hit_r ? rd_data_r.ch : 8'd0;
  assign out_item.read_attr     = read_hit_r ? rd_data_r.attr : 8'd0;

  `TMCW_ASSERT_SAME(a_offset_match, clk, rst_n, 1'b1, offset_r == IDX_W'(row_r * COLUMNS + col_r), "cursor offset out of step")
  `TMCW_ASSERT_SAME(a_copy_in_range, clk, rst_n, ctl.copy, ptr_r >= PTR_COLUMNS && ptr_r <= PTR_CELLS, "scroll pointer out of range")
  `TMCW_ASSERT_SAME(a_cursor_range, clk, rst_n, 1'b1, col_r <= COL_LAST && row_r <= ROW_LAST, "cursor out of range")

endmodule

// ----- rtl/text_mode_console_writer_unit.sv -----
// Top level of the text-mode console writer: register port and block wiring.
// An item is taken when start is high and busy is low; its result appears on
// out_item for exactly one cycle with out_strobe high and cannot be stalled.
// Put character (no scroll), carriage return and read go from the accept
// through the execute state on the screen store to the result cycle, in
// which the next item may already be taken. A put that runs off the bottom
// copies rows up through the store's one read and one write port, one cell
// a cycle, then blanks the last row before the result. Clear walks all 2000
// cells. After reset a clearing pass zeroes all 2000 cells of the store with
// busy high; text_attribute writes are taken at any time.
module text_mode_console_writer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tmcw_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output tmcw_pkg::out_item_t                 out_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmcw_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tmcw_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tmcw_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import tmcw_pkg::*;

  logic [7:0] text_attr_r, text_attr_nxt;
  logic       attr_sel;
  ctl_t       ctl;
  sts_t       sts;

  assign attr_sel = (paddr == ADDR_TEXT_ATTR);
  assign pready   = 1'b1;
  assign prdata   = attr_sel ? CFG_DATA_W'(text_attr_r) : '0;

  always_comb begin
    text_attr_nxt = text_attr_r;
    if (psel && penable && pwrite && attr_sel) begin
      text_attr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= ATTR_RESET;
    end else begin
      text_attr_r <= text_attr_nxt;
    end
  end

  tmcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .sts        (sts),
    .ctl        (ctl)
  );

  tmcw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_item   (in_item),
    .text_attr (text_attr_r),
    .out_item  (out_item)
  );

endmodule

// ----- sim/text_mode_console_writer_unit_tb.sv -----
// Self-checking testbench for the text-mode console writer: screen, cursor and attribute.
module text_mode_console_writer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmcw_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2100;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  logic [7:0] glyph_mem [CELLS];
  logic [7:0] color_mem [CELLS];
  int cur_col;
  int cur_row;
  logic [7:0] text_attr;

  out_item_t awaited_reports [$];
  int failures;
  int items_sent;
  int gap_pct;
  int stall_cycles;

  text_mode_console_writer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t apply_console_command(input in_item_t it);
    out_item_t res;
    int i;
    res = '0;
    case (cmd_code_t'(it.cmd))
      CMD_PUT: begin
        if (it.char_code == CHAR_CR) begin
          cur_col = 0;
        end else if (it.char_code == CHAR_LF) begin
          cur_col = 0;
          cur_row++;
        end else begin
          glyph_mem[cur_row * COLUMNS + cur_col] = it.char_code;
          color_mem[cur_row * COLUMNS + cur_col] = text_attr;
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) begin
            glyph_mem[i] = glyph_mem[i + COLUMNS];
            color_mem[i] = color_mem[i + COLUMNS];
          end
          for (i = CELLS - COLUMNS; i < CELLS; i++) begin
            glyph_mem[i] = CHAR_SPACE;
            color_mem[i] = text_attr;
          end
          cur_row = ROWS - 1;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) begin
          glyph_mem[i] = CHAR_SPACE;
          color_mem[i] = text_attr;
        end
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        if (it.cell_index < CELLS) begin
          res.read_char = glyph_mem[it.cell_index];
          res.read_attr = color_mem[it.cell_index];
        end
      end
      default: ;
    endcase
    res.cursor_col = COL_W'(cur_col);
    res.cursor_row = ROW_W'(cur_row);
    res.cursor_offset = IDX_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  task automatic issue_item(input cmd_code_t cmd, input logic [7:0] ch,
                            input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.cmd = cmd;
    it.char_code = ch;
    it.cell_index = idx;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    awaited_reports.push_back(apply_console_command(it));
    items_sent++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_all_reports();
    start <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_attribute_setting(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TEXT_ATTR;
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    text_attr = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(value)) begin
      $error("text_attribute readback: expected %0d, got %0d", value, prdata);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_edge_cases();
    gap_pct = 30;
    issue_item(CMD_READ, 8'h00, IDX_W'(0));
    issue_item(CMD_READ, 8'hFF, IDX_W'(CELLS - 1));
    issue_item(CMD_READ, 8'h00, IDX_W'(CELLS));
    issue_item(CMD_READ, 8'hFF, {IDX_W{1'b1}});
    issue_item(CMD_NONE, 8'hFF, {IDX_W{1'b1}});
    issue_item(CMD_PUT, 8'h00, IDX_W'(0));
    issue_item(CMD_PUT, 8'hFF, {IDX_W{1'b1}});
    issue_item(CMD_PUT, CHAR_SPACE, IDX_W'(0));
    issue_item(CMD_PUT, 8'h41, IDX_W'(0));
    issue_item(CMD_PUT, CHAR_CR, IDX_W'(0));
    issue_item(CMD_PUT, 8'h42, IDX_W'(0));
    issue_item(CMD_PUT, CHAR_LF, IDX_W'(0));
    issue_item(CMD_READ, 8'h00, IDX_W'(0));
    issue_item(CMD_READ, 8'h00, IDX_W'(1));
    issue_item(CMD_READ, 8'h00, IDX_W'(2));
    issue_item(CMD_READ, 8'h00, IDX_W'(3));
    issue_item(CMD_CLEAR, 8'h00, IDX_W'(0));
    issue_item(CMD_READ, 8'h00, IDX_W'(0));
    issue_item(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
    issue_item(CMD_PUT, 8'h7F, IDX_W'(0));
    issue_item(CMD_PUT, CHAR_LF, IDX_W'(0));
    issue_item(CMD_READ, 8'h00, IDX_W'(0));
  endtask

  task automatic test_random_traffic(input int item_count, input bit with_gaps);
    int stop_at;
    int pick;
    int len;
    stop_at = items_sent + item_count;
    while (items_sent < stop_at) begin
      gap_pct = (with_gaps && $urandom_range(0, 3) != 0) ? 30 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(1, 90);
        repeat (len) issue_item(CMD_PUT, 8'($urandom_range(0, 255)), IDX_W'($urandom));
        case ($urandom_range(0, 3))
          1: issue_item(CMD_PUT, CHAR_LF, IDX_W'($urandom));
          2: begin
            issue_item(CMD_PUT, CHAR_CR, IDX_W'($urandom));
            issue_item(CMD_PUT, CHAR_LF, IDX_W'($urandom));
          end
          3: issue_item(CMD_PUT, CHAR_CR, IDX_W'($urandom));
          default: ;
        endcase
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) begin
            issue_item(CMD_READ, 8'($urandom), IDX_W'($urandom_range(0, 2047)));
          end else begin
            issue_item(CMD_READ, 8'($urandom),
                       IDX_W'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1)));
          end
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 10)) issue_item(CMD_PUT, CHAR_LF, IDX_W'($urandom));
      end else if (pick < 88) begin
        issue_item(cmd_code_t'($urandom_range(0, 3)), 8'($urandom), IDX_W'($urandom));
      end else if (pick < 90) begin
        issue_item(CMD_CLEAR, 8'($urandom), IDX_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          issue_item(CMD_PUT, 8'($urandom_range(0, 31)), IDX_W'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (awaited_reports.size() == 0) begin
        $error("result with no transaction pending");
        failures++;
      end else begin
        want = awaited_reports.pop_front();
        if (out_item.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, out_item.cursor_col);
          failures++;
        end
        if (out_item.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_item.cursor_row);
          failures++;
        end
        if (out_item.cursor_offset !== want.cursor_offset) begin
          $error("cursor_offset: expected %0d, got %0d", want.cursor_offset,
                 out_item.cursor_offset);
          failures++;
        end
        if (out_item.read_char !== want.read_char) begin
          $error("read_char: expected %0d, got %0d", want.read_char, out_item.read_char);
          failures++;
        end
        if (out_item.read_attr !== want.read_attr) begin
          $error("read_attr: expected %0d, got %0d", want.read_attr, out_item.read_attr);
          failures++;
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((rst_n && start && !busy) || out_strobe || (psel && penable)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    failures = 0;
    items_sent = 0;
    gap_pct = 0;
    foreach (glyph_mem[i]) begin
      glyph_mem[i] = 8'h00;
      color_mem[i] = 8'h00;
    end
    cur_col = 0;
    cur_row = 0;
    text_attr = ATTR_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    wait_all_reports();
    test_attribute_setting(8'hFF);
    test_random_traffic(300, 1'b1);
    wait_all_reports();
    test_attribute_setting(8'h00);
    test_random_traffic(300, 1'b1);
    wait_all_reports();
    test_attribute_setting(8'($urandom_range(1, 254)));
    test_random_traffic(300, 1'b1);
    wait_all_reports();
    test_attribute_setting(8'($urandom_range(0, 255)));
    test_random_traffic(250, 1'b0);
    wait_all_reports();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $error("%0d transactions never returned a result", awaited_reports.size());
      failures++;
    end
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
